// ===== rtl/core/bre_pkg.sv =====
// Shared types, constants and a helper function of the branch emulator.
package bre_pkg;

   // Default number of words held between the front and back parts.
   localparam int BRE_QUEUE_DEPTH = 2;

   // Mask that keeps the low 32 bits of an address.
   localparam logic [63:0] LOW32_MASK = 64'h0000_0000_FFFF_FFFF;

   // Instruction kinds as decoded outside the block.
   typedef enum logic [2:0] {
      KIND_NOP   = 3'd0,
      KIND_B     = 3'd1,
      KIND_BC    = 3'd2,
      KIND_BCLR  = 3'd3,
      KIND_BCCTR = 3'd4
   } bre_kind_type;

   // One classified instruction as it travels from front to back.
   typedef struct packed {
      bre_kind_type kind;
      logic [4:0]   bo;
      logic [4:0]   bi;
      logic         aa;
      logic         lk;
      logic [63:0]  disp;
      logic [63:0]  pc;
      logic [63:0]  seq_pc;
      logic [63:0]  link;
      logic [63:0]  count;
      logic [31:0]  cond_reg;
      logic         mode64;
   } bre_item_type;

   // Status of the queue as seen by its neighbours.
   typedef struct packed {
      logic not_empty;
      logic full;
   } bre_qstat_type;

   // Addresses wrap to 32 bits when the block is not in 64-bit mode.
   function automatic logic [63:0] wrap_addr(input logic [63:0] addr, input logic wide);
      wrap_addr = wide ? addr : (addr & LOW32_MASK);
   endfunction

endpackage

// ===== rtl/core/powerpc_branch_emulator.sv =====
// Top level of the branch emulator: front classifier, queue and back resolver.
//
//   Channel   Direction  Handshake            Word
//   req_*     in         req_valid/req_stall  kind, instruction, pc, lr, ctr, cr, mode
//   rsp_*     out        rsp_valid/rsp_stall  next pc, lr, ctr, taken flag
//
// One word is accepted and one result delivered per cycle when neither side stalls.
// A result is offered once its word has passed the front stage, the queue and the
// output register, in that order.
// The back part's target add and count decrement set the cycle time.
// Synchronous reset empties the front stage, the queue and the output register.
// A stall on rsp_* fills the queue and then stalls req_*; each side stalls on its own.
module powerpc_branch_emulator #(
   parameter int QueueDepth = bre_pkg::BRE_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [31:0] req_instr_word,
   input  logic [63:0] req_cur_pc,
   input  logic [63:0] req_link_in,
   input  logic [63:0] req_count_in,
   input  logic [31:0] req_cond_reg,
   input  logic        req_mode64,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_next_pc,
   output logic [63:0] rsp_link_out,
   output logic [63:0] rsp_count_out,
   output logic        rsp_taken
);
   import bre_pkg::*;

   bre_qstat_type q_stat;
   bre_item_type  push_item;
   bre_item_type  pop_item;
   logic          q_push;
   logic          q_pop;

   // Front part.
   bre_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_instr_word (req_instr_word),
      .req_cur_pc     (req_cur_pc),
      .req_link_in    (req_link_in),
      .req_count_in   (req_count_in),
      .req_cond_reg   (req_cond_reg),
      .req_mode64     (req_mode64),
      .q_stat         (q_stat),
      .q_push         (q_push),
      .q_item         (push_item)
   );

   // Queue between the two parts.
   bre_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .stat      (q_stat)
   );

   // Back part.
   bre_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_stat        (q_stat),
      .q_item        (pop_item),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_next_pc   (rsp_next_pc),
      .rsp_link_out  (rsp_link_out),
      .rsp_count_out (rsp_count_out),
      .rsp_taken     (rsp_taken)
   );

endmodule

// ===== rtl/core/bre_front.sv =====
// Front part: accepts instruction words and classifies them into queue items.
module bre_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [2:0]            req_kind,
   input  logic [31:0]           req_instr_word,
   input  logic [63:0]           req_cur_pc,
   input  logic [63:0]           req_link_in,
   input  logic [63:0]           req_count_in,
   input  logic [31:0]           req_cond_reg,
   input  logic                  req_mode64,
   input  bre_pkg::bre_qstat_type q_stat,
   output logic                  q_push,
   output bre_pkg::bre_item_type q_item
);
   import bre_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   bre_item_type item_ff;
   bre_item_type item_in;
   logic         take;

   // The stage holds one word; it can take another when it is empty or draining.
   assign q_push    = valid_ff && !q_stat.full;
   assign req_stall = valid_ff && q_stat.full;
   assign take      = req_valid && !req_stall;
   assign q_item    = item_ff;

   // Classify the kind, pull out the fields and form the sequential address.
   always_comb begin
      item_in.bo       = req_instr_word[25:21];
      item_in.bi       = req_instr_word[20:16];
      item_in.aa       = req_instr_word[1];
      item_in.lk       = req_instr_word[0];
      item_in.pc       = req_cur_pc;
      item_in.link     = req_link_in;
      item_in.count    = req_count_in;
      item_in.cond_reg = req_cond_reg;
      item_in.mode64   = req_mode64;
      item_in.seq_pc   = wrap_addr(req_cur_pc + 64'd4, req_mode64);
      unique case (req_kind)
         KIND_B:     item_in.kind = KIND_B;
         KIND_BC:    item_in.kind = KIND_BC;
         KIND_BCLR:  item_in.kind = KIND_BCLR;
         KIND_BCCTR: item_in.kind = KIND_BCCTR;
         default:    item_in.kind = KIND_NOP;
      endcase
      // The I-form carries a 24-bit word offset, the B-form a 14-bit one.
      if (req_kind == KIND_B) begin
         item_in.disp = {{38{req_instr_word[25]}}, req_instr_word[25:2], 2'b00};
      end else begin
         item_in.disp = {{48{req_instr_word[15]}}, req_instr_word[15:2], 2'b00};
      end
   end

   // Stage valid bit.
   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (q_push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload register.
   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

endmodule

// ===== rtl/core/bre_queue.sv =====
// Short queue of classified words between the front and back parts.
module bre_queue #(
   parameter int Depth = bre_pkg::BRE_QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  bre_pkg::bre_item_type  push_item,
   input  logic                   pop,
   output bre_pkg::bre_item_type  pop_item,
   output bre_pkg::bre_qstat_type stat
);
   import bre_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   bre_item_type    store_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff;
   logic [PtrW-1:0] wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff;
   logic [PtrW-1:0] rd_ptr_in;
   logic [CntW-1:0] count_ff;
   logic [CntW-1:0] count_in;
   logic            do_push;
   logic            do_pop;

   assign stat.full      = (count_ff == CntW'(Depth));
   assign stat.not_empty = (count_ff != '0);
   assign do_push        = push && !stat.full;
   assign do_pop         = pop && stat.not_empty;
   assign pop_item       = store_ff[rd_ptr_ff];

   // Pointers wrap at the depth, which need not be a power of two.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : PtrW'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : PtrW'(rd_ptr_ff + 1'b1);
      end
   end

   // Fill count.
   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = CntW'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CntW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("Queue fill count is above its depth.");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      do_push && !do_pop |=> count_ff == CntW'($past(count_ff) + 1'b1))
      else $error("Queue did not grow on a lone push.");

   a_count_down: assert property (@(posedge clock) disable iff (reset)
      do_pop && !do_push |=> count_ff == CntW'($past(count_ff) - 1'b1))
      else $error("Queue did not shrink on a lone pop.");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("Queue is empty but its pointers differ.");
`endif

endmodule

// ===== rtl/core/bre_back.sv =====
// Back part: resolves each queued branch and holds the result in an output register.
module bre_back (
   input  logic                   clock,
   input  logic                   reset,
   input  bre_pkg::bre_qstat_type q_stat,
   input  bre_pkg::bre_item_type  q_item,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [63:0]            rsp_next_pc,
   output logic [63:0]            rsp_link_out,
   output logic [63:0]            rsp_count_out,
   output logic                   rsp_taken
);
   import bre_pkg::*;

   logic        valid_ff;
   logic        valid_in;
   logic [63:0] next_pc_ff;
   logic [63:0] next_pc_in;
   logic [63:0] link_ff;
   logic [63:0] link_in;
   logic [63:0] count_ff;
   logic [63:0] count_in;
   logic        taken_ff;
   logic        taken_in;
   logic [63:0] base;
   logic [63:0] target;
   logic [63:0] count_dec;
   logic        count_nz;
   logic        ctr_ok;
   logic        cond_ok;
   logic        cr_bit;

   // The output register frees up whenever its word is taken.
   assign q_pop = q_stat.not_empty && (!valid_ff || !rsp_stall);

   // Target address: relative, absolute, or taken from a register.
   always_comb begin
      base = q_item.aa ? 64'd0 : q_item.pc;
      unique case (q_item.kind)
         KIND_BCLR:  target = wrap_addr(q_item.link & ~64'd3, q_item.mode64);
         KIND_BCCTR: target = wrap_addr(q_item.count & ~64'd3, q_item.mode64);
         default:    target = wrap_addr(q_item.disp + base, q_item.mode64);
      endcase
   end

   // Count decrement with its zero test, and the condition bit test.
   always_comb begin
      count_dec = q_item.count - 64'd1;
      count_nz  = q_item.mode64 ? (count_dec != 64'd0) : (count_dec[31:0] != 32'd0);
      ctr_ok    = q_item.bo[2] || (count_nz != q_item.bo[1]);
      // Bit 0 of the condition register is its most significant bit.
      cr_bit    = q_item.cond_reg[~q_item.bi];
      cond_ok   = q_item.bo[4] || (cr_bit == q_item.bo[3]);
   end

   // Result of the instruction.
   always_comb begin
      next_pc_in = q_item.seq_pc;
      link_in    = q_item.link;
      count_in   = q_item.count;
      taken_in   = 1'b0;
      unique case (q_item.kind)
         KIND_B: begin
            next_pc_in = target;
            taken_in   = 1'b1;
            if (q_item.lk) begin
               link_in = q_item.seq_pc;
            end
         end
         KIND_BC, KIND_BCLR, KIND_BCCTR: begin
            taken_in = ctr_ok && cond_ok;
            if (!q_item.bo[2]) begin
               count_in = count_dec;
            end
            if (taken_in) begin
               next_pc_in = target;
            end
            if (q_item.lk) begin
               link_in = q_item.seq_pc;
            end
         end
         default: begin
            next_pc_in = q_item.seq_pc;
         end
      endcase
   end

   // Output valid bit.
   always_comb begin
      valid_in = valid_ff;
      if (q_pop) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Output payload.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         next_pc_ff <= next_pc_in;
         link_ff    <= link_in;
         count_ff   <= count_in;
         taken_ff   <= taken_in;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_next_pc   = next_pc_ff;
   assign rsp_link_out  = link_ff;
   assign rsp_count_out = count_ff;
   assign rsp_taken     = taken_ff;

endmodule
